[sv/ttok_pkg.sv]
// Shared types, constants and the byte map of the text tokenizer.
`default_nettype none

package ttok_pkg;

   // Token store depth per bank and the number of banks.
   localparam int BUF_DEPTH = 32;
   localparam int NUM_BANKS = 2;
   localparam int IDX_W     = $clog2(BUF_DEPTH);
   localparam int BANK_W    = $clog2(NUM_BANKS);
   localparam int ADDR_W    = BANK_W + IDX_W;
   localparam int MEM_DEPTH = NUM_BANKS * BUF_DEPTH;

   // Field widths of the stream items and registers.
   localparam int BYTE_W  = 8;
   localparam int CHAR_W  = 7;
   localparam int CNT_W   = 5;
   localparam int MIN_W   = 5;
   localparam int MAX_W   = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 6;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - CHAR_W - 2 * CNT_W;

   // Longest token the store can hold.
   localparam int CAP_INT  = (BUF_DEPTH - 1 < 31) ? BUF_DEPTH - 1 : 31;
   localparam logic [MAX_W-1:0] CHAR_CAP = MAX_W'(CAP_INT);

   localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(3);
   localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(32);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LEN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_LEN = CSR_IDX_W'(1);

   // Write port of the token store.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [CHAR_W-1:0] data;
   } store_wr_type;

   // A finished token waiting for the back end.
   typedef struct packed {
      logic [BANK_W-1:0] bank;
      logic [CNT_W-1:0]  len;
   } token_desc_type;

   // The back end hands a bank back to the front end.
   typedef struct packed {
      logic              en;
      logic [BANK_W-1:0] bank;
   } bank_release_type;

   // Digits stay, letters fold to lower case, all else maps to zero (delimiter).
   function automatic logic [CHAR_W-1:0] map_byte(input logic [BYTE_W-1:0] b);
      logic [CHAR_W-1:0] res;
      res = '0;
      if (b >= 8'd48 && b <= 8'd57) begin
         res = b[CHAR_W-1:0];
      end else if (b >= 8'd65 && b <= 8'd90) begin
         res = b[CHAR_W-1:0] + CHAR_W'(32);
      end else if (b >= 8'd97 && b <= 8'd122) begin
         res = b[CHAR_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[sv/ttok_front.sv]
// Front end: accepts bytes, classifies them and builds tokens in the store.
`default_nettype none

module ttok_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [ttok_pkg::BYTE_W-1:0]          req_tdata,
   input  wire logic                                 req_tlast,
   input  wire logic                                 csr_valid,
   input  wire logic [ttok_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ttok_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ttok_pkg::store_wr_type                    store_wr,
   output logic                                      desc_valid,
   input  wire logic                                 desc_ready,
   output ttok_pkg::token_desc_type                  desc,
   input  wire ttok_pkg::bank_release_type           release_bank
);

   logic [ttok_pkg::MIN_W-1:0]     min_len_ff, min_len_in;
   logic [ttok_pkg::MAX_W-1:0]     max_len_ff, max_len_in;
   logic [ttok_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                           inside_ff, inside_in;
   logic [ttok_pkg::BANK_W-1:0]    wr_bank_ff, wr_bank_in;
   logic [ttok_pkg::NUM_BANKS-1:0] busy_ff, busy_in;

   logic [ttok_pkg::CHAR_W-1:0]    ch;
   logic [ttok_pkg::MAX_W-1:0]     limit;
   logic                           accept;
   logic                           commit;
   logic [ttok_pkg::CNT_W-1:0]     commit_len;

   assign req_tready = !busy_ff[wr_bank_ff] && desc_ready;
   assign accept     = req_tvalid && req_tready;
   assign ch         = ttok_pkg::map_byte(req_tdata);

   // Effective character limit: the length limit register minus one, capped by the store.
   always_comb begin
      limit = (max_len_ff == '0) ? '0 : max_len_ff - ttok_pkg::MAX_W'(1);
      if (limit > ttok_pkg::CHAR_CAP) begin
         limit = ttok_pkg::CHAR_CAP;
      end
   end

   always_comb begin
      count_in      = count_ff;
      inside_in     = inside_ff;
      commit        = 1'b0;
      commit_len    = count_ff;
      store_wr.en   = 1'b0;
      store_wr.addr = {wr_bank_ff, ttok_pkg::IDX_W'(count_ff)};
      store_wr.data = ch;
      if (accept) begin
         if (ch == '0) begin
            if (inside_ff) begin
               commit    = (count_ff >= min_len_ff);
               inside_in = 1'b0;
               count_in  = '0;
            end
         end else begin
            inside_in = 1'b1;
            if (ttok_pkg::MAX_W'(count_ff) >= limit) begin
               // Token too long: the character is dropped and the token restarts.
               inside_in = 1'b0;
               count_in  = '0;
            end else begin
               store_wr.en = 1'b1;
               count_in    = count_ff + ttok_pkg::CNT_W'(1);
            end
         end
         if (req_tlast) begin
            if (inside_in && !commit) begin
               commit     = 1'b1;
               commit_len = count_in;
            end
            inside_in = 1'b0;
            count_in  = '0;
         end
      end
   end

   assign desc_valid = commit;
   assign desc.bank  = wr_bank_ff;
   assign desc.len   = commit_len;

   always_comb begin
      busy_in    = busy_ff;
      wr_bank_in = wr_bank_ff;
      if (release_bank.en) begin
         busy_in[release_bank.bank] = 1'b0;
      end
      if (commit) begin
         busy_in[wr_bank_ff] = 1'b1;
         wr_bank_in          = wr_bank_ff + ttok_pkg::BANK_W'(1);
      end
   end

   always_comb begin
      min_len_in = min_len_ff;
      max_len_in = max_len_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ttok_pkg::REG_MIN_LEN: min_len_in = csr_wdata[ttok_pkg::MIN_W-1:0];
            ttok_pkg::REG_MAX_LEN: max_len_in = csr_wdata[ttok_pkg::MAX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= ttok_pkg::MIN_RESET;
         max_len_ff <= ttok_pkg::MAX_RESET;
         count_ff   <= '0;
         inside_ff  <= 1'b0;
         wr_bank_ff <= '0;
         busy_ff    <= '0;
      end else begin
         min_len_ff <= min_len_in;
         max_len_ff <= max_len_in;
         count_ff   <= count_in;
         inside_ff  <= inside_in;
         wr_bank_ff <= wr_bank_in;
         busy_ff    <= busy_in;
      end
   end

endmodule

`default_nettype wire

[sv/ttok_queue.sv]
// Two-entry queue of finished token descriptors between front and back end.
`default_nettype none

module ttok_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire ttok_pkg::token_desc_type    in_desc,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output ttok_pkg::token_desc_type         out_desc
);

   ttok_pkg::token_desc_type entry_ff [2];
   logic                     wr_ptr_ff, wr_ptr_in;
   logic                     rd_ptr_ff, rd_ptr_in;
   logic [1:0]               fill_ff, fill_in;
   logic                     push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_desc  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

[sv/ttok_back.sv]
// Back end: token store memory and the sequencer that streams out token characters.
`default_nettype none

module ttok_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ttok_pkg::store_wr_type        store_wr,
   input  wire logic                          desc_valid,
   output logic                               desc_ready,
   input  wire ttok_pkg::token_desc_type      desc,
   output ttok_pkg::bank_release_type         release_bank,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [ttok_pkg::CHAR_W-1:0]        token_char,
   output logic [ttok_pkg::CNT_W-1:0]         char_index,
   output logic [ttok_pkg::CNT_W-1:0]         token_length,
   output logic                               last_char
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_SHOW
   } state_type;

   state_type                     state_ff;
   logic [ttok_pkg::CHAR_W-1:0]   mem_ff [ttok_pkg::MEM_DEPTH];
   logic [ttok_pkg::CHAR_W-1:0]   rd_data_ff;
   logic [ttok_pkg::BANK_W-1:0]   bank_ff;
   logic [ttok_pkg::CNT_W-1:0]    len_ff;
   logic [ttok_pkg::CNT_W-1:0]    idx_ff;
   logic                          valid_ff;
   logic [ttok_pkg::CHAR_W-1:0]   char_ff;
   logic [ttok_pkg::CNT_W-1:0]    out_idx_ff;
   logic                          last_ff;
   logic [ttok_pkg::ADDR_W-1:0]   rd_addr;

   assign rd_addr = {bank_ff, ttok_pkg::IDX_W'(idx_ff)};

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         mem_ff[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign desc_ready        = (state_ff == ST_IDLE);
   assign release_bank.en   = (state_ff == ST_SHOW) && rsp_tready && last_ff;
   assign release_bank.bank = bank_ff;

   assign rsp_tvalid   = valid_ff;
   assign token_char   = char_ff;
   assign char_index   = out_idx_ff;
   assign token_length = len_ff;
   assign last_char    = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (desc_valid) begin
                  bank_ff  <= desc.bank;
                  len_ff   <= desc.len;
                  idx_ff   <= '0;
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               char_ff    <= rd_data_ff;
               out_idx_ff <= idx_ff;
               last_ff    <= (idx_ff + ttok_pkg::CNT_W'(1) == len_ff);
               valid_ff   <= 1'b1;
               state_ff   <= ST_SHOW;
            end
            ST_SHOW: begin
               if (rsp_tready) begin
                  valid_ff <= 1'b0;
                  if (last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + ttok_pkg::CNT_W'(1);
                     state_ff <= ST_FETCH;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

[sv/text_tokenizer_byte_stream.sv]
// Top level of the alphanumeric word tokenizer over a byte stream.
`default_nettype none

// The block takes one text byte per beat on the req_ channel and returns every
// kept token as a run of beats on the rsp_ channel, one beat per character,
// with rsp_tlast on the final character. Digits pass unchanged, Latin letters
// fold to lower case, and every other byte (including bytes 128 to 255) is a
// delimiter. A delimiter ends a token, which is sent if it holds at least the
// minimum length (register 0) and dropped otherwise. A character that arrives
// when the token already holds the length limit (register 1) minus one
// characters (at most 31) is discarded and the token restarts empty. A byte
// with req_tlast set ends the stream: a pending token is flushed regardless of
// the minimum length, and the block is ready for a new stream right after. The
// front end takes one byte per clock cycle while it owns a free bank of the
// two-bank token store; it stalls only when both banks hold finished tokens
// not yet sent. The back end sends the characters one at a time, each through
// memory read, output register load and handshake, and fetches the next one
// only after the current one is taken. Configuration writes on the csr_ port
// are always accepted; they should be issued only while the block is idle.
// Reset is synchronous and active high; the token store itself is not
// cleared and needs no clearing pass.
module text_tokenizer_byte_stream (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Input bytes.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [ttok_pkg::BYTE_W-1:0]          req_tdata,   // [7:0] data_byte
   input  wire logic                                 req_tlast,   // end_of_data
   // Token characters.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [6:0] token_char, [11:7] char_index, [16:12] token_length, [23:17] zero
   output logic [ttok_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                      rsp_tlast,   // last_char
   // Configuration writes: index 0 minimum token length, index 1 token length limit.
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ttok_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ttok_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ttok_pkg::store_wr_type      store_wr;
   ttok_pkg::token_desc_type    front_desc;
   ttok_pkg::token_desc_type    back_desc;
   ttok_pkg::bank_release_type  release_bank;
   logic                        front_desc_valid, front_desc_ready;
   logic                        back_desc_valid, back_desc_ready;
   logic [ttok_pkg::CHAR_W-1:0] token_char;
   logic [ttok_pkg::CNT_W-1:0]  char_index;
   logic [ttok_pkg::CNT_W-1:0]  token_length;

   assign csr_ready = 1'b1;

   ttok_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .store_wr     (store_wr),
      .desc_valid   (front_desc_valid),
      .desc_ready   (front_desc_ready),
      .desc         (front_desc),
      .release_bank (release_bank)
   );

   // Finished tokens wait here until the back end is free.
   ttok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_desc_valid),
      .in_ready  (front_desc_ready),
      .in_desc   (front_desc),
      .out_valid (back_desc_valid),
      .out_ready (back_desc_ready),
      .out_desc  (back_desc)
   );

   ttok_back u_back (
      .clock        (clock),
      .reset        (reset),
      .store_wr     (store_wr),
      .desc_valid   (back_desc_valid),
      .desc_ready   (back_desc_ready),
      .desc         (back_desc),
      .release_bank (release_bank),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .token_char   (token_char),
      .char_index   (char_index),
      .token_length (token_length),
      .last_char    (rsp_tlast)
   );

   assign rsp_tdata = {ttok_pkg::RSP_PAD_W'(0), token_length, char_index, token_char};

endmodule

`default_nettype wire
